// ----- design/lfi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lfi_pkg;

   localparam int MEM_WORDS   = 1024;
   localparam int MEM_ADDR_W  = $clog2(MEM_WORDS);
   localparam int CNT_W       = $clog2(MEM_WORDS + 1);

   localparam int CMD_W       = 2;
   localparam int INDEX_W     = 10;
   localparam int WORD_W      = 32;
   localparam int BIT_W       = 5;
   localparam int ACTIVE_W    = 11;
   localparam int RATE_W      = 10;

   localparam int RATE_SCALE  = 1000;
   localparam int REM_W       = (CNT_W > RATE_W) ? CNT_W : RATE_W;
   localparam int DVD_W       = 32;
   localparam int STEP_W      = $clog2(DVD_W);

   localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'h0000_ACE1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int CSR_IDX_W   = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_WORDS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAULT_RATE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_VALUE   = 2'd2;

   localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INJECT = 2'd2;

   typedef enum logic [1:0] {
      OP_NOP    = 2'd0,
      OP_WRITE  = 2'd1,
      OP_READ   = 2'd2,
      OP_INJECT = 2'd3
   } op_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] word_index;
      logic [WORD_W-1:0]  write_value;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]  read_value;
      logic               fault_done;
      logic [INDEX_W-1:0] fault_word;
      logic [BIT_W-1:0]   fault_bit;
   } rsp_type;

   typedef struct packed {
      op_type                op;
      logic [MEM_ADDR_W-1:0] addr;
      logic [WORD_W-1:0]     write_value;
   } entry_type;

   typedef struct packed {
      logic [CNT_W-1:0]  active_count;
      logic [RATE_W-1:0] fault_rate;
      logic [WORD_W-1:0] seed_value;
   } cfg_type;

endpackage

`default_nettype wire

// ----- design/lfi_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lfi_queue
   import lfi_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output entry_type      pop_entry,
   output logic           empty
);

   entry_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       count_ff, count_in;
   logic                    do_push, do_pop;

   assign full      = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- design/lfi_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lfi_front
   import lfi_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_wdata,
   output logic                      q_push,
   output entry_type                 q_entry,
   input  wire logic                 q_full,
   output cfg_type                   cfg
);

   logic [ACTIVE_W-1:0] active_ff, active_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [WORD_W-1:0]   seed_ff, seed_in;
   logic                in_range;

   always_comb begin
      active_in = active_ff;
      rate_in   = rate_ff;
      seed_in   = seed_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ACTIVE_WORDS: active_in = csr_wdata[ACTIVE_W-1:0];
            CSR_FAULT_RATE:   rate_in   = csr_wdata[RATE_W-1:0];
            CSR_SEED_VALUE:   seed_in   = csr_wdata;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_W'(1024);
         rate_ff   <= '0;
         seed_ff   <= '0;
      end else begin
         active_ff <= active_in;
         rate_ff   <= rate_in;
         seed_ff   <= seed_in;
      end
   end

   // clamp the target count into 1 .. MEM_WORDS
   always_comb begin
      if (active_ff == '0) begin
         cfg.active_count = CNT_W'(1);
      end else if (32'(active_ff) > 32'(MEM_WORDS)) begin
         cfg.active_count = CNT_W'(MEM_WORDS);
      end else begin
         cfg.active_count = CNT_W'(active_ff);
      end
      cfg.fault_rate = rate_ff;
      cfg.seed_value = seed_ff;
   end

   assign in_range  = (32'(req_data.word_index) < 32'(MEM_WORDS));
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_entry.addr        = MEM_ADDR_W'(req_data.word_index);
      q_entry.write_value = req_data.write_value;
      case (req_data.cmd)
         CMD_WRITE:  q_entry.op = in_range ? OP_WRITE : OP_NOP;
         CMD_READ:   q_entry.op = in_range ? OP_READ : OP_NOP;
         CMD_INJECT: q_entry.op = OP_INJECT;
         default:    q_entry.op = OP_NOP;
      endcase
   end

endmodule

`default_nettype wire

// ----- design/lfi_rem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lfi_rem
   import lfi_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [REM_W-1:0] divisor,
   output logic                  done,
   output logic [REM_W-1:0]      remainder
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [DVD_W-1:0]   dvd_ff, dvd_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [REM_W:0]     trial;
   logic [REM_W:0]     div_ext;

   assign trial     = {rem_ff, dvd_ff[DVD_W-1]};
   assign div_ext   = {1'b0, divisor};
   assign done      = done_ff;
   assign remainder = rem_ff;

   // one restoring step per cycle, most significant dividend bit first
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in  = dvd_ff << 1;
         step_in = step_ff + 1'b1;
         if (trial >= div_ext) begin
            rem_in = REM_W'(trial - div_ext);
         end else begin
            rem_in = REM_W'(trial);
         end
         if (step_ff == STEP_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

endmodule

`default_nettype wire

// ----- design/lfi_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lfi_back
   import lfi_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire entry_type q_entry,
   input  wire logic      q_empty,
   output logic           q_pop,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output rsp_type        rsp_data
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_READ    = 5'b00010,
      ST_DIV     = 5'b00100,
      ST_FLIP_RD = 5'b01000,
      ST_FLIP_WR = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [WORD_W-1:0]     gen_ff, gen_in;
   logic                  seeded_ff, seeded_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic [MEM_ADDR_W-1:0] flip_addr_ff, flip_addr_in;
   logic [BIT_W-1:0]      flip_bit_ff, flip_bit_in;
   logic [WORD_W-1:0]     rate_acc_ff, rate_acc_in;

   logic [WORD_W-1:0]     weight_ram [MEM_WORDS];
   logic [WORD_W-1:0]     mem_rdata_ff;
   logic [MEM_ADDR_W-1:0] mem_addr;
   logic                  mem_we;
   logic [WORD_W-1:0]     mem_wdata;

   logic [WORD_W-1:0]     gen_seed;
   logic [WORD_W-1:0]     gen_step;
   logic                  div_start;
   logic                  addr_done;
   logic [REM_W-1:0]      addr_rem;
   logic [WORD_W-1:0]     rate_hi;
   logic [WORD_W-1:0]     rate_fold;
   logic [RATE_W-1:0]     rate_low;
   logic [RATE_W-1:0]     rate_rem;

   assign gen_seed = seeded_ff ? gen_ff
                   : ((cfg.seed_value == '0) ? DEFAULT_SEED : cfg.seed_value);
   assign gen_step = {gen_seed[0] ^ gen_seed[1] ^ gen_seed[21] ^ gen_seed[31],
                      gen_seed[WORD_W-1:1]};

   // fold the bits above ten back in, 2^10 being 24 mod 1000
   assign rate_hi   = rate_acc_ff >> RATE_W;
   assign rate_fold = (rate_hi << 4) + (rate_hi << 3)
                    + {{(WORD_W-RATE_W){1'b0}}, rate_acc_ff[RATE_W-1:0]};
   assign rate_low  = rate_acc_ff[RATE_W-1:0];
   assign rate_rem  = (rate_low >= RATE_W'(RATE_SCALE)) ? rate_low - RATE_W'(RATE_SCALE)
                                                         : rate_low;

   lfi_rem u_addr_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (gen_step ^ cfg.seed_value),
      .divisor   (REM_W'(cfg.active_count)),
      .done      (addr_done),
      .remainder (addr_rem)
   );

   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      seeded_in    = seeded_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      flip_addr_in = flip_addr_ff;
      flip_bit_in  = flip_bit_ff;
      rate_acc_in  = rate_acc_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = q_entry.addr;
      mem_wdata    = q_entry.write_value;
      div_start    = 1'b0;

      // drop the beat once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty && !rsp_valid_ff) begin
               q_pop = 1'b1;
               case (q_entry.op)
                  OP_WRITE: begin
                     mem_we       = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                  end
                  OP_READ: begin
                     state_in = ST_READ;
                  end
                  OP_INJECT: begin
                     gen_in      = gen_step;
                     seeded_in   = 1'b1;
                     rate_acc_in = gen_step;
                     div_start   = 1'b1;
                     state_in    = ST_DIV;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in            = '0;
            rsp_data_in.read_value = mem_rdata_ff;
            state_in               = ST_IDLE;
         end
         ST_DIV: begin
            rate_acc_in = rate_fold;
            if (addr_done) begin
               flip_addr_in = MEM_ADDR_W'(addr_rem);
               flip_bit_in  = gen_ff[20:16];
               if (32'(rate_rem) < 32'(cfg.fault_rate)) begin
                  state_in = ST_FLIP_RD;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_FLIP_RD: begin
            mem_addr = flip_addr_ff;
            state_in = ST_FLIP_WR;
         end
         ST_FLIP_WR: begin
            mem_addr               = flip_addr_ff;
            mem_we                 = 1'b1;
            mem_wdata              = mem_rdata_ff ^ (WORD_W'(1) << flip_bit_ff);
            rsp_valid_in           = 1'b1;
            rsp_data_in            = '0;
            rsp_data_in.fault_done = 1'b1;
            rsp_data_in.fault_word = INDEX_W'(flip_addr_ff);
            rsp_data_in.fault_bit  = flip_bit_ff;
            state_in               = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      flip_addr_ff <= flip_addr_in;
      flip_bit_ff  <= flip_bit_in;
      rate_acc_ff  <= rate_acc_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         weight_ram[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= weight_ram[mem_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_rate_folded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && addr_done |-> rate_acc_ff[WORD_W-1:RATE_W] == '0)
      else $error("rate remainder not settled");

   a_fault_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.fault_done
         |-> 32'(rsp_data_ff.fault_word) < 32'(cfg.active_count))
      else $error("flipped word beyond active count");

   a_fault_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.fault_done |-> rsp_data_ff.read_value == '0)
      else $error("fault beat carries read data");

   a_seeded_holds: assert property (@(posedge clock) disable iff (reset)
      seeded_ff |=> seeded_ff)
      else $error("generator lost its seed");

   a_pop_when_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff != ST_IDLE || rsp_valid_ff)
      else $error("popped item left no trace");
`endif

endmodule

`default_nettype wire

// ----- design/lfsr_bit_flip_fault_injector.sv -----
// Bit-flip fault injector with a 1024-word by 32-bit weight store. Items come
// in on req_* (write word, read word, inject one fault attempt) and each gets
// exactly one beat on rsp_*; configuration registers on csr_* are to be
// written by the user only while the block is idle; the block does not
// enforce this. A two-entry queue sits between the accepting front and the
// executing back, so requests keep landing while a response waits. A queued
// item is not started until the beat before it has been taken. An inject
// computes the bit-serial remainder of (generator xor seed) by the active
// word count, one bit per cycle over the 32-bit generator, while the
// generator mod 1000 is folded down in the same cycles; a flip adds a
// read-modify-write of the single-port store. The generator is seeded on the
// first inject after reset. Words never written read back as undefined.
`timescale 1ns / 1ps
`default_nettype none

module lfsr_bit_flip_fault_injector
   import lfi_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_wdata
);

   cfg_type   cfg;
   entry_type push_entry;
   entry_type pop_entry;
   logic      q_push, q_full, q_pop, q_empty;

   lfi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_push    (q_push),
      .q_entry   (push_entry),
      .q_full    (q_full),
      .cfg       (cfg)
   );

   lfi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   lfi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_entry   (pop_entry),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import lfi_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ACTIVE_WORDS;
   logic [WORD_W-1:0]    csr_wdata = '0;

   // injector state as seen from the ports
   logic [WORD_W-1:0]   model_weights [MEM_WORDS];
   logic [WORD_W-1:0]   model_lfsr   = '0;
   logic                model_seeded = 1'b0;
   logic [ACTIVE_W-1:0] model_active = ACTIVE_W'(MEM_WORDS);
   logic [RATE_W-1:0]   model_rate   = '0;
   logic [WORD_W-1:0]   model_seed   = '0;

   req_type req_backlog [$];
   rsp_type rsp_due [$];

   bit  word_known [MEM_WORDS];
   int  known_list [$];
   int  target_span = MEM_WORDS;
   int  error_count = 0;
   int  beats_seen  = 0;
   int  burst_left  = 1;
   int  gap_left    = 0;
   int  pattern_age = 0;
   int  hold_left   = 0;
   bit  hold_done   = 1'b0;
   logic [15:0] ready_pattern = 16'hFFFF;

   lfsr_bit_flip_fault_injector DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                  logic [WORD_W-1:0] want);
      if (error_count < 40)
         $display("tb: mismatch on %s, got %h, want %h", what, got, want);
      error_count++;
   endtask

   task automatic step_injector(req_type item);
      rsp_type           r;
      logic              feedback;
      logic [WORD_W-1:0] span;
      logic [WORD_W-1:0] addr;
      logic [BIT_W-1:0]  pos;
      r = '0;
      case (item.cmd)
         CMD_WRITE: model_weights[item.word_index] = item.write_value;
         CMD_READ:  r.read_value = model_weights[item.word_index];
         CMD_INJECT: begin
            if (!model_seeded) begin
               model_lfsr   = (model_seed == '0) ? DEFAULT_SEED : model_seed;
               model_seeded = 1'b1;
            end
            feedback   = model_lfsr[0] ^ model_lfsr[1] ^ model_lfsr[21] ^ model_lfsr[31];
            model_lfsr = {feedback, model_lfsr[WORD_W-1:1]};
            if ((model_lfsr % WORD_W'(RATE_SCALE)) < WORD_W'(model_rate)) begin
               if (model_active == '0)
                  span = 1;
               else if (model_active > MEM_WORDS)
                  span = MEM_WORDS;
               else
                  span = WORD_W'(model_active);
               addr = (model_lfsr ^ model_seed) % span;
               pos  = model_lfsr[20:16];
               model_weights[addr[MEM_ADDR_W-1:0]] =
                  model_weights[addr[MEM_ADDR_W-1:0]] ^ (32'd1 << pos);
               r.fault_done = 1'b1;
               r.fault_word = addr[INDEX_W-1:0];
               r.fault_bit  = pos;
            end
         end
         default: ;
      endcase
      rsp_due.push_back(r);
   endtask

   // sender: bursts with gaps, beat held until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ACTIVE_WORDS: model_active = csr_wdata[ACTIVE_W-1:0];
               CSR_FAULT_RATE:   model_rate   = csr_wdata[RATE_W-1:0];
               CSR_SEED_VALUE:   model_seed   = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            step_injector(req_data);
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= req_backlog.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(12, 1);
                  case ($urandom_range(9))
                     0, 1, 2: gap_left = 0;
                     3:       gap_left = $urandom_range(30, 10);
                     default: gap_left = $urandom_range(8, 1);
                  endcase
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: rotating stall pattern, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (beats_seen >= 150 && !hold_done) begin
         hold_done = 1'b1;
         hold_left = 300;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ready_pattern[0];
         ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
         pattern_age++;
         if (pattern_age == 64) begin
            pattern_age = 0;
            case ($urandom_range(3))
               0:       ready_pattern = '1;
               1:       ready_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
               default: ready_pattern = 16'($urandom) | 16'h0001;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_seen <= beats_seen + 1;
         if (rsp_due.size() == 0) begin
            report_mismatch("unexpected beat", rsp_data.read_value, '0);
         end else begin
            want = rsp_due.pop_front();
            if (rsp_data.read_value !== want.read_value)
               report_mismatch("read_value", rsp_data.read_value, want.read_value);
            if (rsp_data.fault_done !== want.fault_done)
               report_mismatch("fault_done", rsp_data.fault_done, want.fault_done);
            if (rsp_data.fault_word !== want.fault_word)
               report_mismatch("fault_word", rsp_data.fault_word, want.fault_word);
            if (rsp_data.fault_bit !== want.fault_bit)
               report_mismatch("fault_bit", rsp_data.fault_bit, want.fault_bit);
         end
      end
   end

   task automatic queue_req(logic [CMD_W-1:0] cmd, int idx, logic [WORD_W-1:0] value);
      req_type r;
      r.cmd         = cmd;
      r.word_index  = INDEX_W'(idx);
      r.write_value = value;
      if (cmd == CMD_WRITE && !word_known[idx]) begin
         word_known[idx] = 1'b1;
         known_list.push_back(idx);
      end
      req_backlog.push_back(r);
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [WORD_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
   endtask

   task automatic configure(int active, int rate, logic [WORD_W-1:0] seed);
      wait_idle();
      repeat (40) @(posedge clock);
      write_csr(CSR_ACTIVE_WORDS, WORD_W'(active));
      write_csr(CSR_FAULT_RATE, WORD_W'(rate));
      write_csr(CSR_SEED_VALUE, seed);
      @(posedge clock);
      csr_we <= 1'b0;
      if (active == 0)
         target_span = 1;
      else if (active > MEM_WORDS)
         target_span = MEM_WORDS;
      else
         target_span = active;
   endtask

   task automatic random_phase(int count);
      int roll;
      int idx;
      // fill small target ranges so flips land on readable words
      if (target_span <= 32)
         for (int w = 0; w < target_span; w++)
            queue_req(CMD_WRITE, w, $urandom);
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(99);
         idx  = $urandom_range(target_span - 1);
         if (roll < 30) begin
            if ($urandom_range(3) == 0)
               idx = $urandom_range(MEM_WORDS - 1);
            queue_req(CMD_WRITE, idx, $urandom);
         end else if (roll < 60) begin
            if (!word_known[idx])
               idx = known_list[$urandom_range(known_list.size() - 1)];
            queue_req(CMD_READ, idx, $urandom);
         end else if (roll < 95) begin
            queue_req(CMD_INJECT, $urandom_range(MEM_WORDS - 1), $urandom);
         end else begin
            queue_req(CMD_UNUSED, $urandom_range(MEM_WORDS - 1), $urandom);
         end
      end
   endtask

   initial begin
      int active;
      int rate;
      logic [WORD_W-1:0] seed;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero seed falls back to the default, zero rate never flips
      queue_req(CMD_WRITE, 0, '0);
      queue_req(CMD_WRITE, 1023, '1);
      queue_req(CMD_WRITE, 341, 32'hAAAA_AAAA);
      queue_req(CMD_WRITE, 682, 32'h5555_5555);
      queue_req(CMD_READ, 0, '1);
      queue_req(CMD_READ, 1023, '0);
      queue_req(CMD_READ, 341, 32'h5555_5555);
      queue_req(CMD_READ, 682, 32'hAAAA_AAAA);
      queue_req(CMD_UNUSED, 1023, '1);
      queue_req(CMD_INJECT, 0, '0);

      // rate above scale, single target word
      configure(1, 1023, '1);
      queue_req(CMD_INJECT, 1023, '1);
      queue_req(CMD_INJECT, 0, '0);
      queue_req(CMD_READ, 0, '0);
      queue_req(CMD_INJECT, 512, 32'h8000_0001);
      queue_req(CMD_READ, 0, '1);

      // count above store, full rate
      configure(2047, 1000, '0);
      queue_req(CMD_INJECT, 0, '0);
      queue_req(CMD_READ, 1023, '0);
      queue_req(CMD_INJECT, 1023, '1);
      queue_req(CMD_READ, 341, '0);
      queue_req(CMD_READ, 682, '0);

      for (int p = 0; p < 9; p++) begin
         seed = $urandom;
         case (p)
            0: begin active = 16;   rate = 1000; end
            1: begin active = 1;    rate = $urandom_range(999, 1); end
            2: begin active = 0;    rate = 1023; seed = '0; end
            3: begin active = $urandom_range(1023, 33); rate = $urandom_range(999, 1); end
            4: begin active = 1024; rate = 1000; seed = '1; end
            5: begin active = 2047; rate = 0; end
            6: begin active = 32;   rate = $urandom_range(999, 1); end
            7: begin active = $urandom_range(31, 2); rate = 1000; end
            default: begin active = $urandom_range(2047, 1); rate = $urandom_range(1023); end
         endcase
         configure(active, rate, seed);
         random_phase(42);
      end

      wait_idle();
      repeat (60) @(posedge clock);
      if (rsp_due.size() != 0)
         report_mismatch("missing beats", rsp_due.size(), '0);
      if (error_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule
